// ===== hw/rtl/emhq_pkg.sv =====
// ============================================================================
// emhq_pkg: shared types and constants of the event min-heap queue
// Entry layout, operation and status codes, controller states, store request.
// ============================================================================
`default_nettype none

package emhq_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 13;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int TAG_W    = 24;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_SLOT  = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_READ,
        S_UP_CMP,
        S_DOWN_READ,
        S_DOWN_CMP,
        S_DEL_CMP,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
        logic   rd_en;
        t_addr  rd_addr_a;
        t_addr  rd_addr_b;
    } t_mem_req;

    // slots count from 1, memory addresses from 0
    function automatic t_addr slot_addr(t_cnt s);
        t_cnt d;
        d = s - 1'b1;
        return d[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/emhq_if.sv =====
// ============================================================================
// emhq_if: request and response channels of the event min-heap queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
`default_nettype none

interface emhq_req_if;
    logic                         valid;
    logic                         ready;
    logic [emhq_pkg::OP_W-1:0]    op;
    logic [emhq_pkg::TIME_W-1:0]  event_time;
    logic [emhq_pkg::KIND_W-1:0]  event_kind;
    logic [emhq_pkg::TAG_W-1:0]   event_tag;
    logic [emhq_pkg::CNT_W-1:0]   slot;

    modport source (output valid, op, event_time, event_kind, event_tag, slot,
                    input ready);
    modport sink   (input valid, op, event_time, event_kind, event_tag, slot,
                    output ready);
endinterface

interface emhq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [emhq_pkg::STAT_W-1:0]  status;
    logic [emhq_pkg::TIME_W-1:0]  got_time;
    logic [emhq_pkg::KIND_W-1:0]  got_kind;
    logic [emhq_pkg::TAG_W-1:0]   got_tag;
    logic [emhq_pkg::CNT_W-1:0]   found_slot;
    logic [emhq_pkg::CNT_W-1:0]   fill_level;

    modport source (output valid, status, got_time, got_kind, got_tag, found_slot,
                    fill_level, input ready);
    modport sink   (input valid, status, got_time, got_kind, got_tag, found_slot,
                    fill_level, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/emhq_store.sv =====
// ============================================================================
// emhq_store: heap entry memory
// One write port and two registered read ports; read data follows the request in the next cycle.
// ============================================================================
`default_nettype none

module emhq_store (
    input  wire logic              i_clk,
    input  wire emhq_pkg::t_mem_req i_req,
    output emhq_pkg::t_entry       o_rd_a,
    output emhq_pkg::t_entry       o_rd_b
);

    emhq_pkg::t_entry mem_array [emhq_pkg::CAPACITY];
    emhq_pkg::t_entry r_rd_a;
    emhq_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem_array[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_a <= mem_array[i_req.rd_addr_a];
            r_rd_b <= mem_array[i_req.rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

// ===== hw/rtl/event_min_heap_queue_top.sv =====
// ============================================================================
// event_min_heap_queue_top: binary min-heap of timed events
// Insert, delete at slot and search by kind and tag over a 4096-entry heap.
// ============================================================================
// One request is worked at a time; the result sits in an output register so
// the next request can be taken while it waits. Every sift level is one read
// of the entry memory followed by one compare-and-write step. A rejected or
// unused request goes straight to the result; an insert climbs from its new
// slot toward the root, a delete moves the last entry into the freed slot and
// sifts it up or down, and a search reads the entries from slot 1 until a
// match or the end of the heap. The next request is taken in the cycle after
// the result is loaded; a result that finds the output register still full
// waits for it to drain. The entry memory needs no clearing after reset.
`default_nettype none

module event_min_heap_queue_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    emhq_req_if.sink   i_req,
    emhq_rsp_if.source o_rsp
);

    emhq_pkg::t_state   r_state, n_state;
    emhq_pkg::t_cnt     r_count, n_count;
    emhq_pkg::t_cnt     r_pos, n_pos;
    emhq_pkg::t_entry   r_item, n_item;
    emhq_pkg::t_cnt     r_scan, n_scan;
    logic               r_cmp_valid, n_cmp_valid;
    emhq_pkg::t_status  r_res_status, n_res_status;
    emhq_pkg::t_entry   r_res_entry, n_res_entry;
    emhq_pkg::t_cnt     r_res_found, n_res_found;
    logic               r_out_valid, n_out_valid;
    emhq_pkg::t_status  r_out_status, n_out_status;
    emhq_pkg::t_entry   r_out_entry, n_out_entry;
    emhq_pkg::t_cnt     r_out_found, n_out_found;
    emhq_pkg::t_cnt     r_out_fill, n_out_fill;

    emhq_pkg::t_mem_req mem_req;
    emhq_pkg::t_entry   rd_a, rd_b;

    emhq_pkg::t_op      req_op;
    logic               in_fire, out_free;
    logic               is_full, bad_slot;
    logic               pos_root, up_move;
    logic [emhq_pkg::CNT_W:0] lc, rc, lc_m1, cnt_ext;
    logic               lc_out, rc_ok, take_l, take_r;
    logic [emhq_pkg::TIME_W-1:0] best_time;
    logic               del_last, gone_lt, gone_gt;
    logic               search_hit, scan_end;

    emhq_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    assign req_op   = emhq_pkg::t_op'(i_req.op);
    assign in_fire  = i_req.valid && (r_state == emhq_pkg::S_IDLE);
    assign out_free = !r_out_valid || o_rsp.ready;

    assign is_full  = r_count >= emhq_pkg::CNT_W'(emhq_pkg::CAPACITY);
    assign bad_slot = (i_req.slot == '0) || (i_req.slot > r_count);

    assign pos_root = r_pos == emhq_pkg::CNT_W'(1);
    assign up_move  = rd_a.ev_time > r_item.ev_time;

    assign lc        = {r_pos, 1'b0};
    assign rc        = {r_pos, 1'b1};
    assign lc_m1     = lc - 1'b1;
    assign cnt_ext   = {1'b0, r_count};
    assign lc_out    = lc > cnt_ext;
    assign rc_ok     = rc <= cnt_ext;
    assign take_l    = r_item.ev_time > rd_a.ev_time;
    assign best_time = take_l ? rd_a.ev_time : r_item.ev_time;
    assign take_r    = rc_ok && (best_time > rd_b.ev_time);

    assign del_last = r_pos > r_count;
    assign gone_lt  = rd_a.ev_time < rd_b.ev_time;
    assign gone_gt  = rd_a.ev_time > rd_b.ev_time;

    assign search_hit = r_cmp_valid && (rd_a.kind == r_item.kind) && (rd_a.tag == r_item.tag);
    assign scan_end   = r_scan > r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emhq_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (req_op)
                        emhq_pkg::OP_INSERT: begin
                            n_state = is_full ? emhq_pkg::S_DONE : emhq_pkg::S_UP_READ;
                        end
                        emhq_pkg::OP_DELETE: begin
                            n_state = bad_slot ? emhq_pkg::S_DONE : emhq_pkg::S_DEL_CMP;
                        end
                        emhq_pkg::OP_SEARCH: n_state = emhq_pkg::S_SEARCH;
                        default:             n_state = emhq_pkg::S_DONE;
                    endcase
                end
            end
            emhq_pkg::S_UP_READ: begin
                n_state = pos_root ? emhq_pkg::S_DONE : emhq_pkg::S_UP_CMP;
            end
            emhq_pkg::S_UP_CMP: begin
                n_state = up_move ? emhq_pkg::S_UP_READ : emhq_pkg::S_DONE;
            end
            emhq_pkg::S_DOWN_READ: begin
                n_state = lc_out ? emhq_pkg::S_DONE : emhq_pkg::S_DOWN_CMP;
            end
            emhq_pkg::S_DOWN_CMP: begin
                n_state = (take_l || take_r) ? emhq_pkg::S_DOWN_READ : emhq_pkg::S_DONE;
            end
            emhq_pkg::S_DEL_CMP: begin
                if (del_last) begin
                    n_state = emhq_pkg::S_DONE;
                end else if (gone_lt) begin
                    n_state = emhq_pkg::S_DOWN_READ;
                end else if (gone_gt) begin
                    n_state = emhq_pkg::S_UP_READ;
                end else begin
                    n_state = emhq_pkg::S_DONE;
                end
            end
            emhq_pkg::S_SEARCH: begin
                if (search_hit || scan_end) begin
                    n_state = emhq_pkg::S_DONE;
                end
            end
            emhq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = emhq_pkg::S_IDLE;
                end
            end
            default: n_state = emhq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_item       = r_item;
        n_scan       = r_scan;
        n_cmp_valid  = r_cmp_valid;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_found  = r_out_found;
        n_out_fill   = r_out_fill;
        mem_req      = '0;

        unique case (r_state)
            emhq_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_res_status = emhq_pkg::STAT_OK;
                    n_res_entry  = '0;
                    n_res_found  = '0;
                    n_item       = '{ev_time: i_req.event_time, kind: i_req.event_kind,
                                     tag: i_req.event_tag};
                    n_scan       = emhq_pkg::CNT_W'(1);
                    n_cmp_valid  = 1'b0;
                    case (req_op)
                        emhq_pkg::OP_INSERT: begin
                            if (is_full) begin
                                n_res_status = emhq_pkg::STAT_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_pos   = r_count + 1'b1;
                            end
                        end
                        emhq_pkg::OP_DELETE: begin
                            if (bad_slot) begin
                                n_res_status = emhq_pkg::STAT_BAD_SLOT;
                            end else begin
                                n_count           = r_count - 1'b1;
                                n_pos             = i_req.slot;
                                mem_req.rd_en     = 1'b1;
                                mem_req.rd_addr_a = emhq_pkg::slot_addr(i_req.slot);
                                mem_req.rd_addr_b = emhq_pkg::slot_addr(r_count);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            emhq_pkg::S_UP_READ: begin
                if (pos_root) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = emhq_pkg::slot_addr(r_pos);
                    mem_req.wr_data = r_item;
                end else begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = emhq_pkg::slot_addr(r_pos >> 1);
                end
            end
            emhq_pkg::S_UP_CMP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = emhq_pkg::slot_addr(r_pos);
                if (up_move) begin
                    mem_req.wr_data = rd_a;
                    n_pos           = r_pos >> 1;
                end else begin
                    mem_req.wr_data = r_item;
                end
            end
            emhq_pkg::S_DOWN_READ: begin
                if (lc_out) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = emhq_pkg::slot_addr(r_pos);
                    mem_req.wr_data = r_item;
                end else begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = lc_m1[emhq_pkg::ADDR_W-1:0];
                    mem_req.rd_addr_b = lc[emhq_pkg::ADDR_W-1:0];
                end
            end
            emhq_pkg::S_DOWN_CMP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = emhq_pkg::slot_addr(r_pos);
                if (take_r) begin
                    mem_req.wr_data = rd_b;
                    n_pos           = rc[emhq_pkg::CNT_W-1:0];
                end else if (take_l) begin
                    mem_req.wr_data = rd_a;
                    n_pos           = lc[emhq_pkg::CNT_W-1:0];
                end else begin
                    mem_req.wr_data = r_item;
                end
            end
            emhq_pkg::S_DEL_CMP: begin
                n_res_entry = rd_a;
                n_item      = rd_b;
                if (!del_last && !gone_lt && !gone_gt) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = emhq_pkg::slot_addr(r_pos);
                    mem_req.wr_data = rd_b;
                end
            end
            emhq_pkg::S_SEARCH: begin
                if (search_hit) begin
                    n_res_found = r_scan - 1'b1;
                end else if (scan_end) begin
                    n_res_status = emhq_pkg::STAT_NOT_FOUND;
                end else begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = emhq_pkg::slot_addr(r_scan);
                    n_scan            = r_scan + 1'b1;
                    n_cmp_valid       = 1'b1;
                end
            end
            emhq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_found  = r_res_found;
                    n_out_fill   = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= emhq_pkg::S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_item       <= n_item;
        r_scan       <= n_scan;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_found  <= n_out_found;
        r_out_fill   <= n_out_fill;
    end

    assign i_req.ready      = (r_state == emhq_pkg::S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.got_time   = r_out_entry.ev_time;
    assign o_rsp.got_kind   = r_out_entry.kind;
    assign o_rsp.got_tag    = r_out_entry.tag;
    assign o_rsp.found_slot = r_out_found;
    assign o_rsp.fill_level = r_out_fill;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= emhq_pkg::CNT_W'(emhq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && req_op == emhq_pkg::OP_INSERT && !is_full)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the heap");

    a_pos_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == emhq_pkg::S_UP_READ || r_state == emhq_pkg::S_DOWN_READ)
        |-> (r_pos != '0 && r_pos <= r_count))
        else $error("sift position outside the heap");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (r_state != emhq_pkg::S_IDLE && r_state != emhq_pkg::S_DONE &&
                           r_state != emhq_pkg::S_SEARCH))
        else $error("entry write outside a sift");
`endif

endmodule

`default_nettype wire
